// File: hw/rtl/bwp_pkg.sv
// ----------------------------------------------------------------------------
// bwp_pkg
// Shared types and constants of the bilinear warp pixel pipeline.
// ----------------------------------------------------------------------------
package bwp_pkg;

    localparam int CODE_W     = 24;
    localparam int PIX_W      = 8;
    localparam int FRAC_BITS  = 5;
    localparam int WHOLE_BITS = 7;
    localparam int WEIGHT_W   = FRAC_BITS + 1;
    localparam int OFFS_W     = 8;
    localparam int VSUM_W     = PIX_W + FRAC_BITS;
    localparam int BLEND_W    = PIX_W + 2 * FRAC_BITS;
    localparam int DIM_SHIFT  = 15;
    localparam int DIM_LOG    = 5;
    localparam int SCALED_W   = BLEND_W + DIM_LOG;

    localparam logic [WEIGHT_W-1:0] FRAC_ONE   = WEIGHT_W'(32);
    localparam logic [OFFS_W-1:0]   COORD_BIAS = OFFS_W'(63);
    localparam logic [PIX_W-1:0]    PIX_MAX    = PIX_W'(247);

    typedef struct packed {
        logic [OFFS_W-1:0]    offset_x;
        logic [OFFS_W-1:0]    offset_y;
        logic [FRAC_BITS-1:0] frac_x;
        logic [WEIGHT_W-1:0]  wght_x;
        logic [VSUM_W-1:0]    sum_left;
        logic [VSUM_W-1:0]    sum_right;
    } t_vert;

    typedef struct packed {
        logic [OFFS_W-1:0]  offset_x;
        logic [OFFS_W-1:0]  offset_y;
        logic [BLEND_W-1:0] blend;
    } t_horz;

endpackage

// File: hw/rtl/bwp_vert.sv
// ----------------------------------------------------------------------------
// bwp_vert
// First stage: decodes the displacement and blends each column vertically.
// ----------------------------------------------------------------------------
module bwp_vert
    import bwp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CODE_W-1:0] i_coded_delta,
    input  logic [PIX_W-1:0]  i_pix_tl,
    input  logic [PIX_W-1:0]  i_pix_tr,
    input  logic [PIX_W-1:0]  i_pix_bl,
    input  logic [PIX_W-1:0]  i_pix_br,
    output logic              o_valid,
    input  logic              i_ready,
    output t_vert             o_data
);

    localparam int PROD_W = PIX_W + WEIGHT_W;

    logic                  r_vld;
    t_vert                 r_data;
    t_vert                 n_data;
    logic [FRAC_BITS-1:0]  w_fy;
    logic [WEIGHT_W-1:0]   w_gy;
    logic [PROD_W-1:0]     w_left;
    logic [PROD_W-1:0]     w_right;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        w_fy    = i_coded_delta[FRAC_BITS-1:0];
        w_gy    = FRAC_ONE - {1'b0, w_fy};
        w_left  = PROD_W'(i_pix_tl) * PROD_W'(w_gy) + PROD_W'(i_pix_bl) * PROD_W'(w_fy);
        w_right = PROD_W'(i_pix_tr) * PROD_W'(w_gy) + PROD_W'(i_pix_br) * PROD_W'(w_fy);

        n_data.frac_x    = i_coded_delta[12 +: FRAC_BITS];
        n_data.wght_x    = FRAC_ONE - {1'b0, i_coded_delta[12 +: FRAC_BITS]};
        n_data.offset_x  = {1'b0, i_coded_delta[12 + FRAC_BITS +: WHOLE_BITS]} - COORD_BIAS;
        n_data.offset_y  = {1'b0, i_coded_delta[FRAC_BITS +: WHOLE_BITS]} - COORD_BIAS;
        n_data.sum_left  = w_left[VSUM_W-1:0];
        n_data.sum_right = w_right[VSUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

// File: hw/rtl/bwp_horz.sv
// ----------------------------------------------------------------------------
// bwp_horz
// Second stage: blends the two column sums horizontally.
// ----------------------------------------------------------------------------
module bwp_horz
    import bwp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_vert i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_horz o_data
);

    localparam int PROD_W = BLEND_W + 1;

    logic              r_vld;
    t_horz             r_data;
    t_horz             n_data;
    logic [PROD_W-1:0] w_sum;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        w_sum = PROD_W'(i_data.frac_x) * PROD_W'(i_data.sum_right)
              + PROD_W'(i_data.wght_x) * PROD_W'(i_data.sum_left);
        n_data.offset_x = i_data.offset_x;
        n_data.offset_y = i_data.offset_y;
        n_data.blend    = w_sum[BLEND_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

// File: hw/rtl/bwp_scale.sv
// ----------------------------------------------------------------------------
// bwp_scale
// Output stage: dims the blend by 31/32768 and holds the result word.
// ----------------------------------------------------------------------------
module bwp_scale
    import bwp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_horz              i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [OFFS_W-1:0]  o_offset_x,
    output logic [OFFS_W-1:0]  o_offset_y,
    output logic [PIX_W-1:0]   o_pixel
);

    logic                r_vld;
    logic [OFFS_W-1:0]   r_offset_x;
    logic [OFFS_W-1:0]   r_offset_y;
    logic [PIX_W-1:0]    r_pixel;
    logic [SCALED_W-1:0] w_scaled;

    assign o_ready  = !r_vld || i_ready;
    assign w_scaled = {i_data.blend, DIM_LOG'(0)} - SCALED_W'(i_data.blend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_offset_x <= i_data.offset_x;
            r_offset_y <= i_data.offset_y;
            r_pixel    <= w_scaled[DIM_SHIFT +: PIX_W];
        end
    end

    assign o_valid    = r_vld;
    assign o_offset_x = r_offset_x;
    assign o_offset_y = r_offset_y;
    assign o_pixel    = r_pixel;

endmodule

// File: hw/rtl/bilinear_warp_pixel.sv
// An accepted input word passes the vert, horz and scale registers in turn to its result word.
// Throughput: one word per cycle, set by three register stages that each
// take a new word whenever the stage after them has room.
// Reset clears the valid bit of every stage; no valid word is held across reset.
// ----------------------------------------------------------------------------
// bilinear_warp_pixel
// Per-pixel warp kernel: unbiased whole offsets and a dimmed bilinear blend.
// ----------------------------------------------------------------------------
module bilinear_warp_pixel
    import bwp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // coded_delta[23:0], pix_top_left[31:24], pix_top_right[39:32],
    // pix_bottom_left[47:40], pix_bottom_right[55:48]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // offset_x[7:0], offset_y[15:8], blended_pixel[23:16]
    output logic [23:0] m_axis_tdata
);

    logic              w_v1;
    logic              w_v2;
    logic              w_r2;
    logic              w_r3;
    t_vert             w_d1;
    t_horz             w_d2;
    logic [OFFS_W-1:0] w_ox;
    logic [OFFS_W-1:0] w_oy;
    logic [PIX_W-1:0]  w_pix;

    bwp_vert u_vert (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_coded_delta (s_axis_tdata[23:0]),
        .i_pix_tl      (s_axis_tdata[31:24]),
        .i_pix_tr      (s_axis_tdata[39:32]),
        .i_pix_bl      (s_axis_tdata[47:40]),
        .i_pix_br      (s_axis_tdata[55:48]),
        .o_valid       (w_v1),
        .i_ready       (w_r2),
        .o_data        (w_d1)
    );

    bwp_horz u_horz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r2),
        .i_data  (w_d1),
        .o_valid (w_v2),
        .i_ready (w_r3),
        .o_data  (w_d2)
    );

    bwp_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_v2),
        .o_ready    (w_r3),
        .i_data     (w_d2),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_offset_x (w_ox),
        .o_offset_y (w_oy),
        .o_pixel    (w_pix)
    );

    assign m_axis_tdata = {w_pix, w_oy, w_ox};

`ifndef ASSERT_OFF
    // A full pipeline facing a stalled consumer must refuse new words.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v1 && w_v2 && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the pipeline is full and stalled");

    a_pix_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_pix <= PIX_MAX))
        else $error("blended pixel above its ceiling");

    a_offs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(w_ox) >= -8'sd63 && $signed(w_ox) <= 8'sd64
                           && $signed(w_oy) >= -8'sd63 && $signed(w_oy) <= 8'sd64))
        else $error("offset out of range");

    // The column sums feed a product that must stay within the blend width.
    a_vsum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v1 |-> (w_d1.sum_left <= VSUM_W'(8160) && w_d1.sum_right <= VSUM_W'(8160)))
        else $error("column sum out of range");
`endif

endmodule
